FILE: rtl/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and constants of the packed pixel rectangle fill block
// Item layouts, register indexes, opcodes, buffer geometry and depth helpers.
// ----------------------------------------------------------------------------
package ppr_pkg;

	// buffer geometry
	localparam int BUF_BYTES = 16384;
	localparam int ADDR_W    = $clog2(BUF_BYTES);
	// offset (8) + row product (26) + column byte offset (14) needs 27 bits
	localparam int FULL_W    = 27;
	localparam int PROD_W    = 26;
	localparam int XOFF_W    = 14;

	// opcodes
	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_FILL    = 2'd2;
	localparam logic [1:0] OP_OUTLINE = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_BPP    = 2'd0;
	localparam logic [1:0] REG_STRIDE = 2'd1;
	localparam logic [1:0] REG_OFFSET = 2'd2;

	// register reset values
	localparam logic [4:0]  BPP_RST    = 5'd8;
	localparam logic [12:0] STRIDE_RST = 13'd64;
	localparam logic [7:0]  OFFSET_RST = 8'd0;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [11:0] rect_width;
		logic [11:0] rect_height;
		logic [15:0] pixel_value;
	} cmd_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic        error_flag;
	} res_t;

	typedef struct packed {
		logic [4:0]  bits_per_pixel;
		logic [12:0] bytes_per_row;
		logic [7:0]  data_offset;
	} cfg_t;

	// answer of the address unit for the pixel handed in the cycle before
	typedef struct packed {
		logic              outside;
		logic [ADDR_W-1:0] addr;
	} addr_res_t;

	// byte memory access request from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// supported depths: 1, 2, 4, 8, 16
	function automatic logic depth_ok(input logic [4:0] bpp);
		depth_ok = (bpp == 5'd1) || (bpp == 5'd2) || (bpp == 5'd4) ||
			(bpp == 5'd8) || (bpp == 5'd16);
	endfunction

	// log2 of a supported depth
	function automatic logic [2:0] depth_log2(input logic [4:0] bpp);
		logic [2:0] lg;
		case (bpp)
			5'd2:    lg = 3'd1;
			5'd4:    lg = 3'd2;
			5'd8:    lg = 3'd3;
			5'd16:   lg = 3'd4;
			default: lg = 3'd0;
		endcase
		depth_log2 = lg;
	endfunction

endpackage

FILE: rtl/ppr_ram.sv
// ----------------------------------------------------------------------------
// ppr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ppr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/ppr_addr.sv
// ----------------------------------------------------------------------------
// ppr_addr: shared pixel address unit
// Registers row * stride and the column byte offset, then adds the data
// offset and checks the pixel against the end of the buffer.
// ----------------------------------------------------------------------------
module ppr_addr (
	input  logic              clk,
	input  ppr_pkg::cfg_t     cfg,
	input  logic [12:0]       cx,
	input  logic [12:0]       cy,
	output ppr_pkg::addr_res_t res
);

	logic [ppr_pkg::PROD_W-1:0] prod_s1;
	logic [ppr_pkg::XOFF_W-1:0] xoff_s1;
	logic [16:0]                bit_pos;
	logic [ppr_pkg::FULL_W-1:0] full;
	logic [ppr_pkg::FULL_W-1:0] limit;

	// column bit position: x shifted by log2 of the depth
	assign bit_pos = {4'd0, cx} << ppr_pkg::depth_log2(cfg.bits_per_pixel);

	// product stage
	always_ff @(posedge clk) begin
		prod_s1 <= ppr_pkg::PROD_W'(cy) * ppr_pkg::PROD_W'(cfg.bytes_per_row);
		xoff_s1 <= bit_pos[16:3];
	end

	// sum and bounds check; a 16 bit pixel needs its second byte inside too
	always_comb begin
		full  = ppr_pkg::FULL_W'(cfg.data_offset) + ppr_pkg::FULL_W'(prod_s1) +
			ppr_pkg::FULL_W'(xoff_s1);
		limit = (cfg.bits_per_pixel == 5'd16) ?
			ppr_pkg::FULL_W'(ppr_pkg::BUF_BYTES - 1) : ppr_pkg::FULL_W'(ppr_pkg::BUF_BYTES);
		res.outside = (full >= limit);
		res.addr    = full[ppr_pkg::ADDR_W-1:0];
	end

endmodule

FILE: rtl/ppr_ctrl.sv
// ----------------------------------------------------------------------------
// ppr_ctrl: command sequencer
// Clears the buffer after reset, splits each command into spans, walks the
// pixels of each span through the address unit and does the byte
// read-modify-write.
// ----------------------------------------------------------------------------
module ppr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  ppr_pkg::cfg_t      cfg,
	input  logic               start,
	input  ppr_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done,
	output ppr_pkg::res_t      result,
	output logic [12:0]        cx,
	output logic [12:0]        cy,
	input  ppr_pkg::addr_res_t ares,
	output ppr_pkg::ram_req_t  ram_req,
	input  logic [7:0]         ram_rdata
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_WR   = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]                  state_q;
	logic [ppr_pkg::ADDR_W-1:0]  clr_q;
	ppr_pkg::cmd_t               cmd_q;
	logic [11:0]                 row_q;
	logic [1:0]                  seg_q;
	logic [12:0]                 cx_q;
	logic [12:0]                 cy_q;
	logic                        vert_q;
	logic [11:0]                 len_q;
	logic [11:0]                 i_q;
	logic [ppr_pkg::ADDR_W-1:0]  addr_q;
	logic                        byte_q;
	logic [15:0]                 rdv_q;
	logic                        err_q;

	// span sequencing
	logic [11:0] h_eff;
	logic        seg_abort;
	logic        nxt_done;
	logic [12:0] nxt_x;
	logic [12:0] nxt_y;
	logic        nxt_vert;
	logic [11:0] nxt_len;
	logic [11:0] row_n;
	logic [1:0]  seg_n;

	// pixel byte handling
	logic        is16;
	logic        is8;
	logic [16:0] bit_pos;
	logic [2:0]  sh;
	logic [3:0]  sh_w;
	logic [7:0]  mask;
	logic [7:0]  merged;
	logic [7:0]  extracted;
	logic        pix_last;
	logic        is_read;

	assign is16    = (cfg.bits_per_pixel == 5'd16);
	assign is8     = (cfg.bits_per_pixel == 5'd8);
	assign is_read = (cmd_q.opcode == ppr_pkg::OP_READ);
	assign h_eff   = (cfg.bytes_per_row == 13'd0) ? 12'd1 : cmd_q.rect_height;
	assign row_n   = row_q + 12'd1;
	assign seg_n   = seg_q + 2'd1;
	assign pix_last = ((i_q + 12'd1) == len_q);

	// a fill row whose first pixel is outside ends the whole fill
	assign seg_abort = (state_q == ST_ADD) && ares.outside && (i_q == 12'd0);

	// next span of the command
	always_comb begin
		nxt_done = 1'b1;
		nxt_x    = 13'(cmd_q.pos_x);
		nxt_y    = 13'(cmd_q.pos_y);
		nxt_vert = 1'b0;
		nxt_len  = cmd_q.rect_width;
		case (cmd_q.opcode)
			ppr_pkg::OP_FILL: begin
				nxt_done = seg_abort || (row_n == h_eff);
				nxt_y    = 13'(cmd_q.pos_y) + 13'(row_n);
			end
			ppr_pkg::OP_OUTLINE: begin
				nxt_done = (seg_q == 2'd3);
				case (seg_n)
					2'd1: begin
						nxt_y = 13'(cmd_q.pos_y) + 13'(cmd_q.rect_height) - 13'd1;
					end
					2'd2: begin
						nxt_vert = 1'b1;
						nxt_len  = h_eff;
					end
					default: begin
						nxt_x    = 13'(cmd_q.pos_x) + 13'(cmd_q.rect_width) - 13'd1;
						nxt_vert = 1'b1;
						nxt_len  = h_eff;
					end
				endcase
			end
			default: begin
				nxt_done = 1'b1;
			end
		endcase
	end

	// sub-byte position and mask; pixels are packed msb first
	always_comb begin
		bit_pos   = {4'd0, cx_q} << ppr_pkg::depth_log2(cfg.bits_per_pixel);
		sh_w      = 4'd8 - cfg.bits_per_pixel[3:0] - {1'b0, bit_pos[2:0]};
		sh        = sh_w[2:0];
		mask      = 8'((9'd1 << cfg.bits_per_pixel[3:0]) - 9'd1);
		extracted = (ram_rdata >> sh) & mask;
		if (is16) begin
			merged = byte_q ? cmd_q.pixel_value[7:0] : cmd_q.pixel_value[15:8];
		end else if (is8) begin
			merged = cmd_q.pixel_value[7:0];
		end else begin
			merged = (ram_rdata & ~(mask << sh)) | ((cmd_q.pixel_value[7:0] & mask) << sh);
		end
	end

	// memory port requests
	always_comb begin
		ram_req.raddr = addr_q + ppr_pkg::ADDR_W'(byte_q);
		if (state_q == ST_CLR) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = clr_q;
			ram_req.wdata = 8'd0;
		end else begin
			ram_req.we    = (state_q == ST_WR) && !is_read;
			ram_req.waddr = addr_q + ppr_pkg::ADDR_W'(byte_q);
			ram_req.wdata = merged;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			row_q   <= '0;
			seg_q   <= '0;
			i_q     <= '0;
			byte_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						row_q  <= '0;
						seg_q  <= '0;
						i_q    <= '0;
						byte_q <= 1'b0;
						if (!ppr_pkg::depth_ok(cfg.bits_per_pixel)) begin
							err_q   <= 1'b1;
							state_q <= ST_DONE;
						end else if (cmd.opcode[1] &&
							(cmd.rect_width == 12'd0 || cmd.rect_height == 12'd0)) begin
							err_q   <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							err_q   <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					byte_q <= 1'b0;
					if (ares.outside) begin
						err_q <= 1'b1;
						i_q   <= '0;
						if (nxt_done) begin
							state_q <= ST_DONE;
						end else begin
							row_q   <= row_n;
							seg_q   <= seg_n;
							state_q <= ST_MUL;
						end
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (is16 && !byte_q) begin
						byte_q  <= 1'b1;
						state_q <= ST_RD;
					end else if (!pix_last) begin
						i_q     <= i_q + 12'd1;
						state_q <= ST_MUL;
					end else begin
						i_q <= '0;
						if (nxt_done) begin
							state_q <= ST_DONE;
						end else begin
							row_q   <= row_n;
							seg_q   <= seg_n;
							state_q <= ST_MUL;
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item, position and address registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q  <= cmd;
					cx_q   <= 13'(cmd.pos_x);
					cy_q   <= 13'(cmd.pos_y);
					vert_q <= 1'b0;
					len_q  <= cmd.opcode[1] ? cmd.rect_width : 12'd1;
					rdv_q  <= '0;
				end
			end
			ST_ADD: begin
				addr_q <= ares.addr;
				if (ares.outside && !nxt_done) begin
					cx_q   <= nxt_x;
					cy_q   <= nxt_y;
					vert_q <= nxt_vert;
					len_q  <= nxt_len;
				end
			end
			ST_WR: begin
				// capture read bytes, high byte first for 16 bit pixels
				if (is_read) begin
					if (is16) begin
						if (byte_q) begin
							rdv_q[7:0] <= ram_rdata;
						end else begin
							rdv_q[15:8] <= ram_rdata;
						end
					end else if (is8) begin
						rdv_q <= {8'd0, ram_rdata};
					end else begin
						rdv_q <= {8'd0, extracted};
					end
				end
				// step to the next pixel or span
				if (!(is16 && !byte_q)) begin
					if (!pix_last) begin
						if (vert_q) begin
							cy_q <= cy_q + 13'd1;
						end else begin
							cx_q <= cx_q + 13'd1;
						end
					end else if (!nxt_done) begin
						cx_q   <= nxt_x;
						cy_q   <= nxt_y;
						vert_q <= nxt_vert;
						len_q  <= nxt_len;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign cx                = cx_q;
	assign cy                = cy_q;
	assign busy              = (state_q != ST_IDLE);
	assign done              = (state_q == ST_DONE);
	assign result.read_value = rdv_q;
	assign result.error_flag = err_q;

endmodule

FILE: rtl/packed_pixel_rect_fill_top.sv
// ----------------------------------------------------------------------------
// packed_pixel_rect_fill_top: packed pixel buffer with rectangle commands
// Each visited pixel passes MUL, ADD, RD and WR (RD and WR twice at 16 bpp);
// a pixel outside ends after ADD; rejected or empty commands go to DONE.
// Throughput: one item at a time; the pixel walk through the shared address
// unit and the single byte memory port sets the rate. Results cannot stall.
// Reset: asynchronous; afterwards a clearing pass zeroes the
// buffer with busy high. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module packed_pixel_rect_fill_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ppr_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output ppr_pkg::res_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [12:0]   cfg_data
);

	ppr_pkg::cfg_t      cfg_q;
	ppr_pkg::addr_res_t ares;
	ppr_pkg::ram_req_t  ram_req;
	logic [7:0]         ram_rdata;
	logic [12:0]        cx;
	logic [12:0]        cy;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bits_per_pixel <= ppr_pkg::BPP_RST;
			cfg_q.bytes_per_row  <= ppr_pkg::STRIDE_RST;
			cfg_q.data_offset    <= ppr_pkg::OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppr_pkg::REG_BPP:    cfg_q.bits_per_pixel <= cfg_data[4:0];
				ppr_pkg::REG_STRIDE: cfg_q.bytes_per_row  <= cfg_data;
				ppr_pkg::REG_OFFSET: cfg_q.data_offset    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	ppr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cx        (cx),
		.cy        (cy),
		.ares      (ares),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	ppr_addr u_addr (
		.clk (clk),
		.cfg (cfg_q),
		.cx  (cx),
		.cy  (cy),
		.res (ares)
	);

	ppr_ram #(
		.WIDTH (8),
		.DEPTH (ppr_pkg::BUF_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

FILE: rtl/ppr_chk.sv
// ----------------------------------------------------------------------------
// ppr_chk: port-level checks for the packed pixel rectangle fill block
// Watches the command and result handshake of the top level.
// ----------------------------------------------------------------------------
module ppr_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input ppr_pkg::res_t result
);

	// a result strobe lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting an item");

	// results come only while an item is in work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// a read value is only reported by a clean read
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.read_value != 16'd0) |-> !result.error_flag)
		else $error("nonzero read value together with an error");

endmodule

bind packed_pixel_rect_fill_top ppr_chk u_chk (.*);

FILE: bench/packed_pixel_rect_fill_top_test.sv
// ----------------------------------------------------------------------------
// packed_pixel_rect_fill_top_test: self-checking bench for the pixel buffer
// Drives read, write, fill and outline commands over a range of depths,
// strides and offsets, keeps its own copy of the byte buffer, and checks
// every result strobe against the predicted read value and error flag.
// ----------------------------------------------------------------------------
module packed_pixel_rect_fill_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned wide_t;

	localparam int    STORE_BYTES = ppr_pkg::BUF_BYTES;
	localparam wide_t STORE_LIMIT = STORE_BYTES;
	localparam int    SETTINGS_FIXED = 11;
	localparam int    SETTINGS_TOTAL = 14;
	localparam int    ITEMS_PER_SETTING = 118;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          start     = 1'b0;
	ppr_pkg::cmd_t cmd       = '0;
	logic          busy;
	logic          done;
	ppr_pkg::res_t result;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [1:0]    cfg_index = '0;
	logic [12:0]   cfg_data  = '0;

	// shadow of the pixel buffer and of the registers
	logic [7:0]  frame_bytes [STORE_BYTES];
	logic [4:0]  cur_bpp    = ppr_pkg::BPP_RST;
	logic [12:0] cur_stride = ppr_pkg::STRIDE_RST;
	logic [7:0]  cur_offset = ppr_pkg::OFFSET_RST;

	ppr_pkg::cmd_t queued_cmds [$];
	ppr_pkg::res_t pending_results [$];

	int issued;
	int accepted;
	int op_count [4];
	int results_seen;
	int flagged;
	int faults;
	int settings_run;
	bit sender_steady;
	logic [2:0] hold_off;

	// register setting table: depth, stride, offset
	int set_bpp    [SETTINGS_FIXED] = '{1, 2, 4, 16, 8, 6, 16, 1, 0, 31, 2};
	int set_stride [SETTINGS_FIXED] = '{64, 1, 8191, 64, 0, 64, 4096, 0, 128, 8191, 7};
	int set_offset [SETTINGS_FIXED] = '{0, 255, 17, 8, 3, 0, 255, 255, 0, 255, 100};

	packed_pixel_rect_fill_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// buffer prediction
	// ------------------------------------------------------------------
	function automatic bit depth_known();
		return cur_bpp == 5'd1 || cur_bpp == 5'd2 || cur_bpp == 5'd4 ||
			cur_bpp == 5'd8 || cur_bpp == 5'd16;
	endfunction

	function automatic wide_t byte_of(wide_t x, wide_t y);
		wide_t offs, stride, depth;
		offs = cur_offset;
		stride = cur_stride;
		depth = cur_bpp;
		return offs + y * stride + (x * depth) / 8;
	endfunction

	// whole pixel lies inside the buffer
	function automatic bit fits(wide_t x, wide_t y);
		wide_t a;
		a = byte_of(x, y);
		if (cur_bpp == 5'd16)
			return a + 1 < STORE_LIMIT;
		return a < STORE_LIMIT;
	endfunction

	// bit position of a packed pixel, msb first
	function automatic int unsigned bit_shift(wide_t x);
		wide_t depth;
		depth = cur_bpp;
		return (8 - int'(cur_bpp)) - int'((x * depth) & 7);
	endfunction

	function automatic logic [15:0] pixel_get(wide_t x, wide_t y);
		wide_t a;
		int unsigned mask, sel;
		a = byte_of(x, y);
		mask = (1 << cur_bpp) - 1;
		if (cur_bpp == 5'd16)
			return {frame_bytes[a], frame_bytes[a + 1]};
		if (cur_bpp == 5'd8)
			return {8'h00, frame_bytes[a]};
		sel = (frame_bytes[a] >> bit_shift(x)) & mask;
		return sel[15:0];
	endfunction

	// returns 1 when the pixel falls outside and nothing was written
	function automatic bit pixel_put(wide_t x, wide_t y, logic [15:0] v);
		wide_t a;
		int unsigned mask, sh, val, merged;
		if (!fits(x, y))
			return 1'b1;
		a = byte_of(x, y);
		mask = (1 << cur_bpp) - 1;
		val = v & mask;
		if (cur_bpp == 5'd16) begin
			frame_bytes[a] = val[15:8];
			frame_bytes[a + 1] = val[7:0];
		end else if (cur_bpp == 5'd8) begin
			frame_bytes[a] = val[7:0];
		end else begin
			sh = bit_shift(x);
			merged = (frame_bytes[a] & ~(mask << sh)) | (val << sh);
			frame_bytes[a] = merged[7:0];
		end
		return 1'b0;
	endfunction

	// horizontal run stops at the first pixel past the buffer end
	function automatic bit walk_row(wide_t x, wide_t y, wide_t w, logic [15:0] v);
		for (wide_t i = 0; i < w; i++)
			if (pixel_put(x + i, y, v))
				return 1'b1;
		return 1'b0;
	endfunction

	// vertical run; zero stride folds every row onto the first
	function automatic bit walk_col(wide_t x, wide_t y, wide_t h, logic [15:0] v);
		if (h != 0 && cur_stride == 0)
			h = 1;
		for (wide_t i = 0; i < h; i++)
			if (pixel_put(x, y + i, v))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic ppr_pkg::res_t draw_command(ppr_pkg::cmd_t c);
		ppr_pkg::res_t r;
		wide_t x, y, w, h;
		logic [15:0] v;
		r = '0;
		x = c.pos_x;
		y = c.pos_y;
		w = c.rect_width;
		h = c.rect_height;
		v = c.pixel_value;
		if (!depth_known()) begin
			r.error_flag = 1'b1;
		end else if (c.opcode == ppr_pkg::OP_READ) begin
			if (fits(x, y))
				r.read_value = pixel_get(x, y);
			else
				r.error_flag = 1'b1;
		end else if (c.opcode == ppr_pkg::OP_WRITE) begin
			r.error_flag = pixel_put(x, y, v);
		end else if (w != 0 && h != 0) begin
			if (c.opcode == ppr_pkg::OP_FILL) begin
				if (cur_stride == 0)
					h = 1;
				for (wide_t row = 0; row < h; row++) begin
					if (walk_row(x, y + row, w, v)) begin
						r.error_flag = 1'b1;
						// later rows start even further out
						if (!fits(x, y + row))
							break;
					end
				end
			end else begin
				if (walk_row(x, y, w, v)) r.error_flag = 1'b1;
				if (walk_row(x, y + h - 1, w, v)) r.error_flag = 1'b1;
				if (walk_col(x, y, h, v)) r.error_flag = 1'b1;
				if (walk_col(x + w - 1, y, h, v)) r.error_flag = 1'b1;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic ppr_pkg::cmd_t make_cmd(logic [1:0] op, int x, int y, int w, int h,
			int v);
		ppr_pkg::cmd_t c;
		c.opcode = op;
		c.pos_x = x[11:0];
		c.pos_y = y[11:0];
		c.rect_width = w[11:0];
		c.rect_height = h[11:0];
		c.pixel_value = v[15:0];
		return c;
	endfunction

	function automatic ppr_pkg::cmd_t random_cmd();
		ppr_pkg::cmd_t c;
		int unsigned pick, depth;
		longint ylim, room, xb, stride_l, offs_l;
		c.opcode = 2'($urandom_range(0, 3));
		c.pixel_value = 16'($urandom_range(0, 65535));
		c.pos_x = 12'($urandom_range(0, 47));
		c.pos_y = 12'($urandom_range(0, 15));
		c.rect_width = 12'($urandom_range(0, 6));
		c.rect_height = 12'($urandom_range(0, 6));
		pick = $urandom_range(0, 999);
		stride_l = cur_stride;
		offs_l = cur_offset;
		if (pick < 650) begin
			// small region so reads land on earlier writes
		end else if (pick < 850) begin
			c.pos_x = 12'($urandom_range(0, 4095));
			c.pos_y = 12'($urandom_range(0, 4095));
		end else if (pick < 985) begin
			// aim at the last row and column before the buffer end
			depth = depth_known() ? cur_bpp : 8;
			if (stride_l == 0)
				ylim = $urandom_range(0, 4095);
			else
				ylim = (STORE_BYTES - offs_l) / stride_l - $urandom_range(0, 1);
			if (ylim < 0) ylim = 0;
			if (ylim > 4095) ylim = 4095;
			room = STORE_BYTES - offs_l - ylim * stride_l;
			if (room < 0) room = 0;
			xb = room * 8 / depth - $urandom_range(0, 3);
			if (xb < 0) xb = 0;
			if (xb > 4095) xb = 4095;
			c.pos_x = xb[11:0];
			c.pos_y = ylim[11:0];
		end else begin
			// a few large rectangles, kept to one long run or far outside
			case ($urandom_range(0, 2))
				0: begin
					c.rect_width = 12'($urandom_range(0, 4095));
					c.rect_height = 12'd1;
				end
				1: begin
					c.rect_width = 12'd1;
					c.rect_height = 12'($urandom_range(0, 4095));
				end
				default: begin
					c.rect_width = 12'($urandom_range(0, 4095));
					if (stride_l >= 8) begin
						c.rect_height = 12'($urandom_range(0, 4095));
						c.pos_y = 12'd4095;
					end else begin
						c.rect_height = 12'd1;
					end
				end
			endcase
		end
		return c;
	endfunction

	task automatic queue_cmd(input ppr_pkg::cmd_t c);
		queued_cmds.push_back(c);
		issued++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[12:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ppr_pkg::REG_BPP:    cur_bpp = val[4:0];
			ppr_pkg::REG_STRIDE: cur_stride = val[12:0];
			default:             cur_offset = val[7:0];
		endcase
	endtask

	// wait until every item is taken and every result has come back
	task automatic settle();
		do @(posedge clk);
		while (accepted != issued || pending_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// command driver: takes items from the queue; unless steady, random gaps between them
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic go;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			hold_off <= '0;
		end else begin
			go = start;
			if (start && !busy) begin
				pending_results.push_back(draw_command(cmd));
				op_count[cmd.opcode]++;
				accepted++;
				go = 1'b0;
			end
			if (!go) begin
				if (hold_off != 0) begin
					hold_off <= hold_off - 3'd1;
				end else if (queued_cmds.size() != 0) begin
					cmd <= queued_cmds.pop_front();
					go = 1'b1;
					hold_off <= sender_steady ? 3'd0 : 3'($urandom_range(0, 5));
				end
			end
			start <= go;
		end
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_proc
		ppr_pkg::res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: result with nothing outstanding: read_value %h error_flag %b",
						$realtime, result.read_value, result.error_flag);
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (want.error_flag)
					flagged++;
				if (result.read_value !== want.read_value ||
						result.error_flag !== want.error_flag) begin
					faults++;
					if (faults <= 10)
						$display("%0t: read_value exp %h got %h, error_flag exp %b got %b",
							$realtime, want.read_value, result.read_value,
							want.error_flag, result.error_flag);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// run sequence
	// ------------------------------------------------------------------
	initial begin : run_proc
		int bpp, stride, offs;
		foreach (frame_bytes[i])
			frame_bytes[i] = 8'h00;
		sender_steady = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed items at the reset setting: 8 bpp, stride 64, offset 0
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 0, 0, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_WRITE, 0, 0, 4095, 4095, 16'hFFFF));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 0, 0, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_WRITE, 4095, 0, 0, 0, 16'h00A5));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 4095, 0, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_WRITE, 4095, 4095, 0, 0, 16'h1234));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 4095, 4095, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_WRITE, 63, 255, 0, 0, 16'h005A));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 63, 255, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 0, 256, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_FILL, 2, 3, 5, 4, 16'h0033));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 4, 5, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_OUTLINE, 10, 10, 6, 5, 16'h0077));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 10, 12, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 12, 12, 0, 0, 0));
		// empty rectangles draw and flag nothing
		queue_cmd(make_cmd(ppr_pkg::OP_FILL, 30, 1, 0, 5, 16'h0044));
		queue_cmd(make_cmd(ppr_pkg::OP_OUTLINE, 30, 1, 3, 0, 16'h0044));
		// fill running off the end of the buffer
		queue_cmd(make_cmd(ppr_pkg::OP_FILL, 60, 254, 8, 4, 16'h0011));
		queue_cmd(make_cmd(ppr_pkg::OP_OUTLINE, 0, 4095, 4095, 4095, 16'hFFFF));
		queue_cmd(make_cmd(ppr_pkg::OP_FILL, 0, 20, 4095, 1, 16'h000F));
		queue_cmd(make_cmd(ppr_pkg::OP_OUTLINE, 5, 0, 1, 4095, 16'h00EE));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 5, 100, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_READ, 100, 20, 0, 0, 0));
		queue_cmd(make_cmd(ppr_pkg::OP_FILL, 4095, 4095, 4095, 4095, 16'hFFFF));
		settle();

		// random items under a sequence of register settings
		for (int s = 0; s < SETTINGS_TOTAL; s++) begin
			if (s < SETTINGS_FIXED) begin
				bpp = set_bpp[s];
				stride = set_stride[s];
				offs = set_offset[s];
			end else begin
				case ($urandom_range(0, 4))
					0: bpp = 1;
					1: bpp = 2;
					2: bpp = 4;
					3: bpp = 8;
					default: bpp = 16;
				endcase
				stride = $urandom_range(1, 200);
				offs = $urandom_range(0, 255);
			end
			write_reg(ppr_pkg::REG_BPP, bpp);
			write_reg(ppr_pkg::REG_STRIDE, stride);
			write_reg(ppr_pkg::REG_OFFSET, offs);
			settings_run++;
			sender_steady = (s % 4 == 3);
			for (int n = 0; n < ITEMS_PER_SETTING; n++)
				queue_cmd(random_cmd());
			settle();
		end

		faults += pending_results.size();
		$display("%0d items over %0d register settings: %0d reads, %0d writes, %0d fills, %0d outlines",
			accepted, settings_run + 1, op_count[ppr_pkg::OP_READ], op_count[ppr_pkg::OP_WRITE],
			op_count[ppr_pkg::OP_FILL], op_count[ppr_pkg::OP_OUTLINE]);
		$display("%0d results checked, %0d of them flagged, %0d faults",
			results_seen, flagged, faults);
		if (faults == 0)
			$display("packed_pixel_rect_fill_top_test: clean");
		else
			$display("packed_pixel_rect_fill_top_test: errors");
		$finish;
	end

	// run limit, far past the slowest legal run
	initial begin : limit_proc
		#120_000_000;
		$display("run limit reached with %0d items outstanding", issued - accepted);
		$display("packed_pixel_rect_fill_top_test: errors");
		$finish;
	end

endmodule
